>>> rtl/core/buddy_block_allocator_unit_assert.svh
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BBA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy allocator assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy allocator assertion failed");

`endif

>>> rtl/core/bba_pkg.sv
// Types and constants of the buddy block allocator.
package bba_pkg;

	localparam int MAX_LEVELS = 10;
	localparam int POOL_BITS  = 20;
	localparam int SIZE_W     = POOL_BITS + 1;
	localparam int OFF_W      = POOL_BITS;
	localparam int LVL_W      = 4;
	localparam int IDX_W      = MAX_LEVELS + 1;
	localparam int NODE_COUNT = (1 << IDX_W) - 1;

	localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(1048576);

	// Node codes held in the tree memory
	typedef enum logic [1:0] {
		NODE_EMPTY = 2'd0,
		NODE_SPLIT = 2'd1,
		NODE_FULL  = 2'd2
	} node_state_t;

	// Search sequencer
	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_READ     = 6'b000010,
		ST_EVAL     = 6'b000100,
		ST_WR_RIGHT = 6'b001000,
		ST_NEXT     = 6'b010000,
		ST_DONE     = 6'b100000
	} seq_state_t;

endpackage

>>> rtl/core/buddy_block_allocator_unit.sv
// Buddy allocator: depth-first search over a node-state tree kept in one RAM.
// Per node: ST_READ, then ST_EVAL; a split of an empty node adds ST_WR_RIGHT,
// and each sibling or upward step passes through ST_NEXT.
// One request at a time: in_ready is high only in ST_IDLE; ST_DONE waits for a free output.
// Reset: pool size returns to 1048576 and the tree reads as all empty at once
// (root tracked by a flag; other nodes are cleared when their parent splits).
module buddy_block_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bba_pkg::SIZE_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bba_pkg::SIZE_W-1:0]  request_size,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        alloc_status,
	output logic [bba_pkg::OFF_W-1:0]   block_offset,
	output logic [bba_pkg::LVL_W-1:0]   block_level
);
	import bba_pkg::*;

	seq_state_t          state_q;
	logic [SIZE_W-1:0]   pool_size_q;
	logic [SIZE_W-1:0]   req_q;
	logic [IDX_W-1:0]    idx_q;
	logic [LVL_W-1:0]    level_q;
	logic [SIZE_W-1:0]   base_q;
	logic                root_init_q;
	logic                force_empty_q;
	node_state_t         mem_rdata_q;
	logic                res_status_q;
	logic [OFF_W-1:0]    res_offset_q;
	logic [LVL_W-1:0]    res_level_q;
	logic                out_valid_q;
	logic                out_status_q;
	logic [OFF_W-1:0]    out_offset_q;
	logic [LVL_W-1:0]    out_level_q;

	node_state_t         node_mem [NODE_COUNT];

	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	node_state_t         mem_wdata;
	logic [SIZE_W-1:0]   node_size;
	node_state_t         cur_st;
	logic [IDX_W-1:0]    left_idx;
	logic [IDX_W-1:0]    right_idx;
	logic [IDX_W-1:0]    parent_idx;
	logic                at_bottom;
	logic                fits;
	logic                no_split;
	logic                out_free;

	// Node geometry
	assign node_size  = pool_size_q >> level_q;
	assign left_idx   = {idx_q[IDX_W-2:0], 1'b1};
	assign right_idx  = {idx_q[IDX_W-2:0], 1'b0} + IDX_W'(2);
	assign parent_idx = {1'b0, idx_q[IDX_W-1:1]} - IDX_W'(1);
	assign at_bottom  = (level_q == LVL_W'(MAX_LEVELS));
	assign fits       = (req_q <= node_size);
	assign no_split   = (req_q > (node_size >> 1)) || at_bottom;
	assign out_free   = !out_valid_q || out_ready;

	// State of the node under test: known empty after a split, root empty until first write
	always_comb begin
		if (force_empty_q || (idx_q == '0 && !root_init_q)) begin
			cur_st = NODE_EMPTY;
		end else begin
			cur_st = mem_rdata_q;
		end
	end

	// Tree RAM write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = NODE_FULL;
		case (state_q)
			ST_EVAL: begin
				if (cur_st == NODE_EMPTY && fits) begin
					mem_we    = 1'b1;
					mem_wdata = no_split ? NODE_FULL : NODE_SPLIT;
				end
			end
			ST_WR_RIGHT: begin
				mem_we    = 1'b1;
				mem_waddr = right_idx;
				mem_wdata = NODE_EMPTY;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Tree RAM, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_READ) begin
			mem_rdata_q <= node_mem[idx_q];
		end
	end

	// Pool size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_RESET;
		end else if (cfg_wr_en) begin
			pool_size_q <= cfg_wr_data;
		end
	end

	// Root written flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_init_q <= 1'b0;
		end else if (mem_we && mem_waddr == '0) begin
			root_init_q <= 1'b1;
		end
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			force_empty_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					force_empty_q <= 1'b0;
					state_q       <= ST_EVAL;
				end
				ST_EVAL: begin
					case (cur_st)
						NODE_EMPTY: begin
							if (!fits) begin
								state_q <= ST_NEXT;
							end else if (no_split) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_WR_RIGHT;
							end
						end
						NODE_SPLIT: begin
							state_q <= (fits && !at_bottom) ? ST_READ : ST_NEXT;
						end
						default: begin
							state_q <= ST_NEXT;
						end
					endcase
				end
				ST_WR_RIGHT: begin
					force_empty_q <= 1'b1;
					state_q       <= ST_EVAL;
				end
				ST_NEXT: begin
					if (idx_q == '0) begin
						state_q <= ST_DONE;
					end else if (idx_q[0]) begin
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search position, request and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q   <= request_size;
				idx_q   <= '0;
				level_q <= '0;
				base_q  <= '0;
			end
			ST_EVAL: begin
				if (cur_st == NODE_EMPTY && fits && no_split) begin
					res_status_q <= 1'b0;
					res_offset_q <= base_q[OFF_W-1:0];
					res_level_q  <= level_q;
				end else if (cur_st == NODE_SPLIT && fits && !at_bottom) begin
					idx_q   <= left_idx;
					level_q <= level_q + LVL_W'(1);
				end
			end
			ST_WR_RIGHT: begin
				idx_q   <= left_idx;
				level_q <= level_q + LVL_W'(1);
			end
			ST_NEXT: begin
				if (idx_q == '0) begin
					res_status_q <= 1'b1;
					res_offset_q <= '0;
					res_level_q  <= '0;
				end else if (idx_q[0]) begin
					// left child refused: move to its sibling
					idx_q  <= idx_q + IDX_W'(1);
					base_q <= base_q + node_size;
				end else begin
					// right child refused: parent is exhausted too
					idx_q   <= parent_idx;
					base_q  <= base_q - node_size;
					level_q <= level_q - LVL_W'(1);
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_offset_q <= res_offset_q;
			out_level_q  <= res_level_q;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign alloc_status = out_status_q;
	assign block_offset = out_offset_q;
	assign block_level  = out_level_q;

	`include "buddy_block_allocator_unit_assert.svh"

	`BBA_ASSERT_NEXT(a_accept_starts_read, in_valid && in_ready, state_q == ST_READ)
	`BBA_ASSERT_IMPL(a_refusal_is_zero, out_valid && alloc_status, block_offset == '0 && block_level == '0)
	`BBA_ASSERT_IMPL(a_level_bound, state_q != ST_IDLE, level_q <= LVL_W'(MAX_LEVELS))
	`BBA_ASSERT_IMPL(a_split_clears_right, state_q == ST_WR_RIGHT, mem_we && mem_wdata == NODE_EMPTY)

endmodule
